// ===== hw/rtl/mbet_pkg.sv =====
`default_nettype none

package mbet_pkg;

    localparam int FRAC_BITS   = 28;
    localparam int WORD_W      = FRAC_BITS + 4;
    localparam int PROD_W      = 2 * WORD_W;
    localparam int COORD_WIDTH = 12;
    localparam int COUNT_WIDTH = 16;
    localparam int SIZE_W      = 13;
    localparam int STEP_W      = 31;
    localparam int DIFF_W      = SIZE_W + 2;
    localparam int ADDR_W      = 24;
    localparam int LEVEL_W     = 8;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;

    typedef logic signed [WORD_W-1:0] word_t;

    localparam word_t QMAX = {1'b0, {(WORD_W-1){1'b1}}};
    localparam word_t QMIN = {1'b1, {(WORD_W-1){1'b0}}};
    localparam word_t FOUR = word_t'(64'd4 << FRAC_BITS);

    localparam logic [LEVEL_W-1:0] LEVEL_ESC    = 8'd255;
    localparam logic [LEVEL_W-1:0] LEVEL_INSIDE = 8'd0;

    localparam logic [STEP_W-1:0]      STEP_RESET   = 31'd1048576;
    localparam logic [SIZE_W-1:0]      WIDTH_RESET  = 13'd640;
    localparam logic [SIZE_W-1:0]      HEIGHT_RESET = 13'd480;
    localparam logic [COUNT_WIDTH-1:0] MAXIT_RESET  = 16'd256;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CENTER_RE    = 3'd0,
        REG_CENTER_IM    = 3'd1,
        REG_PIXEL_STEP   = 3'd2,
        REG_IMAGE_WIDTH  = 3'd3,
        REG_IMAGE_HEIGHT = 3'd4,
        REG_MAX_ITER     = 3'd5
    } reg_index_t;

    typedef struct packed {
        word_t                   center_re;
        word_t                   center_im;
        logic [STEP_W-1:0]       pixel_step;
        logic [SIZE_W-1:0]       image_width;
        logic [SIZE_W-1:0]       image_height;
        logic [COUNT_WIDTH-1:0]  max_iterations;
    } cfg_t;

    typedef struct packed {
        logic load_in;
        logic map_mul;
        logic map_add;
        logic iter_mul;
        logic iter_upd;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic iter_done;
    } status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/mbet_pixel_if.sv =====
`default_nettype none

interface mbet_pixel_if import mbet_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [COORD_WIDTH-1:0] pixel_x;
    logic [COORD_WIDTH-1:0] pixel_y;

    modport source (output valid, output pixel_x, output pixel_y, input ready);
    modport sink (input valid, input pixel_x, input pixel_y, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/mbet_result_if.sv =====
`default_nettype none

interface mbet_result_if import mbet_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic                   escaped;
    logic [COUNT_WIDTH-1:0] iteration_count;
    logic [LEVEL_W-1:0]     pixel_level;
    logic [ADDR_W-1:0]      pixel_address;

    modport source (
        output valid, output escaped, output iteration_count,
        output pixel_level, output pixel_address, input ready
    );
    modport sink (
        input valid, input escaped, input iteration_count,
        input pixel_level, input pixel_address, output ready
    );
endinterface

`default_nettype wire

// ===== hw/rtl/mbet_core.sv =====
`default_nettype none

// Computes the Mandelbrot escape time of one pixel per item in signed Q4.28
// saturating fixed point. A result is loaded once the iterations of its item,
// at most max_iterations, are done, and the next item can be accepted in the
// cycle after the load. The time per item is set by the iteration loop, in
// which three 32 x 32 bit multipliers form zx*zx, zy*zy and zx*zy into
// registers and the saturating update and escape test follow in the next
// cycle. One item is worked on at a time. A new item is taken while the
// previous result still waits in the output register, but the next result
// is not loaded, and no further item is taken, until that one is read.
module mandelbrot_escape_time_pixel_core
    import mbet_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    mbet_pixel_if.sink                 pixel,
    mbet_result_if.source              result,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t    cfg;
    cmd_t    cmd;
    status_t status;

    mbet_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    mbet_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pixel.valid),
        .in_ready  (pixel.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .status    (status),
        .cmd       (cmd)
    );

    mbet_dp u_dp (
        .clk             (clk),
        .cfg             (cfg),
        .cmd             (cmd),
        .status          (status),
        .pixel_x         (pixel.pixel_x),
        .pixel_y         (pixel.pixel_y),
        .escaped         (result.escaped),
        .iteration_count (result.iteration_count),
        .pixel_level     (result.pixel_level),
        .pixel_address   (result.pixel_address)
    );

    a_busy_after_accept: assert property (
        @(posedge clk) disable iff (!rst_n)
        (pixel.valid && pixel.ready) |=> !pixel.ready
    ) else $error("Input is still ready in the cycle after an item was taken.");

    a_valid_from_load: assert property (
        @(posedge clk) disable iff (!rst_n)
        $rose(result.valid) |-> $past(cmd.load_out)
    ) else $error("Result valid rose without a result load.");

    a_escape_consistent: assert property (
        @(posedge clk) disable iff (!rst_n)
        result.valid |->
            (result.escaped == (result.iteration_count < cfg.max_iterations))
    ) else $error("Escaped flag disagrees with the iteration count.");

    a_count_bound: assert property (
        @(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.iteration_count <= cfg.max_iterations)
    ) else $error("Iteration count exceeds the limit.");

endmodule

`default_nettype wire

// ===== hw/rtl/mbet_cfg.sv =====
`default_nettype none

module mbet_cfg
    import mbet_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                       cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (reg_index_t'(cfg_index))
                REG_CENTER_RE:    cfg_next.center_re      = word_t'(cfg_data);
                REG_CENTER_IM:    cfg_next.center_im      = word_t'(cfg_data);
                REG_PIXEL_STEP:   cfg_next.pixel_step     = cfg_data[STEP_W-1:0];
                REG_IMAGE_WIDTH:  cfg_next.image_width    = cfg_data[SIZE_W-1:0];
                REG_IMAGE_HEIGHT: cfg_next.image_height   = cfg_data[SIZE_W-1:0];
                REG_MAX_ITER:     cfg_next.max_iterations = cfg_data[COUNT_WIDTH-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.center_re      <= '0;
            cfg_reg.center_im      <= '0;
            cfg_reg.pixel_step     <= STEP_RESET;
            cfg_reg.image_width    <= WIDTH_RESET;
            cfg_reg.image_height   <= HEIGHT_RESET;
            cfg_reg.max_iterations <= MAXIT_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/mbet_ctrl.sv =====
`default_nettype none

module mbet_ctrl
    import mbet_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_ready,
    output logic         out_valid,
    input  wire logic    out_ready,
    input  wire status_t status,
    output cmd_t         cmd
);

    typedef enum logic [5:0] {
        ST_IDLE     = 6'b000001,
        ST_MAP_MUL  = 6'b000010,
        ST_MAP_ADD  = 6'b000100,
        ST_ITER_MUL = 6'b001000,
        ST_ITER_UPD = 6'b010000,
        ST_FINISH   = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_MAP_MUL;
                end
            end
            ST_MAP_MUL:
            begin
                cmd.map_mul = 1'b1;
                state_next  = ST_MAP_ADD;
            end
            ST_MAP_ADD:
            begin
                cmd.map_add = 1'b1;
                state_next  = ST_ITER_MUL;
            end
            ST_ITER_MUL:
            begin
                cmd.iter_mul = 1'b1;
                state_next   = ST_ITER_UPD;
            end
            ST_ITER_UPD:
            begin
                cmd.iter_upd = 1'b1;
                state_next   = status.iter_done ? ST_FINISH : ST_ITER_MUL;
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/mbet_dp.sv =====
`default_nettype none

module mbet_dp
    import mbet_pkg::*;
(
    input  wire logic                   clk,
    input  wire cfg_t                   cfg,
    input  wire cmd_t                   cmd,
    output status_t                     status,
    input  wire logic [COORD_WIDTH-1:0] pixel_x,
    input  wire logic [COORD_WIDTH-1:0] pixel_y,
    output logic                        escaped,
    output logic [COUNT_WIDTH-1:0]      iteration_count,
    output logic [LEVEL_W-1:0]          pixel_level,
    output logic [ADDR_W-1:0]           pixel_address
);

    function automatic word_t sat_add(input word_t a, input word_t b);
        logic signed [WORD_W:0] s;
        s = {a[WORD_W-1], a} + {b[WORD_W-1], b};
        if (s[WORD_W] != s[WORD_W-1])
        begin
            return s[WORD_W] ? QMIN : QMAX;
        end
        return s[WORD_W-1:0];
    endfunction

    // Shifts a product magnitude right, applies the sign and saturates.
    function automatic word_t mul_sat(input logic [PROD_W-1:0] p, input logic neg,
                                      input int unsigned sh);
        logic [PROD_W-1:0] q;
        word_t             m;
        q = p >> sh;
        m = word_t'(q[WORD_W-1:0]);
        if (q[PROD_W-1:WORD_W-1] != '0)
        begin
            return neg ? QMIN : QMAX;
        end
        return neg ? -m : m;
    endfunction

    logic [COORD_WIDTH-1:0] px_reg;
    logic [COORD_WIDTH-1:0] py_reg;
    logic [PROD_W-1:0]      prod_reg [3];
    logic [PROD_W-1:0]      prod_next [3];
    logic [2:0]             sgn_reg;
    logic [2:0]             sgn_next;
    word_t                  cx_reg;
    word_t                  cy_reg;
    word_t                  zx_reg;
    word_t                  zy_reg;
    logic [COUNT_WIDTH-1:0] count_reg;
    logic [ADDR_W-1:0]      addr_reg;
    logic                   esc_out_reg;
    logic [COUNT_WIDTH-1:0] count_out_reg;
    logic [LEVEL_W-1:0]     level_out_reg;
    logic [ADDR_W-1:0]      addr_out_reg;

    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
    logic [DIFF_W-2:0]        dx_mag;
    logic [DIFF_W-2:0]        dy_mag;
    logic [WORD_W-1:0]        zx_mag;
    logic [WORD_W-1:0]        zy_mag;
    logic [WORD_W-1:0]        mul_a [3];
    logic [WORD_W-1:0]        mul_b [3];

    word_t xx;
    word_t yy;
    word_t xy2;
    word_t mag2;
    word_t cx_new;
    word_t cy_new;
    logic  esc_now;

    assign dx = $signed({2'b00, px_reg, 1'b0}) - $signed({2'b00, cfg.image_width});
    assign dy = $signed({2'b00, py_reg, 1'b0}) - $signed({2'b00, cfg.image_height});
    assign dx_mag = dx[DIFF_W-1] ? (DIFF_W-1)'(-dx) : (DIFF_W-1)'(dx);
    assign dy_mag = dy[DIFF_W-1] ? (DIFF_W-1)'(-dy) : (DIFF_W-1)'(dy);
    assign zx_mag = zx_reg[WORD_W-1] ? (~zx_reg + 1'b1) : zx_reg;
    assign zy_mag = zy_reg[WORD_W-1] ? (~zy_reg + 1'b1) : zy_reg;

    always_comb
    begin
        if (cmd.map_mul)
        begin
            mul_a[0] = WORD_W'(dx_mag);
            mul_b[0] = WORD_W'(cfg.pixel_step);
            mul_a[1] = WORD_W'(dy_mag);
            mul_b[1] = WORD_W'(cfg.pixel_step);
            mul_a[2] = WORD_W'(py_reg);
            mul_b[2] = WORD_W'(cfg.image_width);
            sgn_next = {1'b0, dy[DIFF_W-1], dx[DIFF_W-1]};
        end
        else
        begin
            mul_a[0] = zx_mag;
            mul_b[0] = zx_mag;
            mul_a[1] = zy_mag;
            mul_b[1] = zy_mag;
            mul_a[2] = zx_mag;
            mul_b[2] = zy_mag;
            sgn_next = {zx_reg[WORD_W-1] ^ zy_reg[WORD_W-1], 2'b00};
        end
        for (int k = 0; k < 3; k++)
        begin
            prod_next[k] = PROD_W'(mul_a[k]) * PROD_W'(mul_b[k]);
        end
    end

    always_comb
    begin
        xx      = mul_sat(prod_reg[0], 1'b0, FRAC_BITS);
        yy      = mul_sat(prod_reg[1], 1'b0, FRAC_BITS);
        xy2     = mul_sat(prod_reg[2], sgn_reg[2], FRAC_BITS - 1);
        mag2    = sat_add(xx, yy);
        esc_now = (mag2 >= FOUR);
        cx_new  = sat_add(mul_sat(sgn_reg[0] ? prod_reg[0] + 1'b1 : prod_reg[0],
                                  sgn_reg[0], 1), cfg.center_re);
        cy_new  = sat_add(mul_sat(sgn_reg[1] ? prod_reg[1] + 1'b1 : prod_reg[1],
                                  sgn_reg[1], 1), cfg.center_im);
    end

    assign status.iter_done = esc_now || (count_reg >= cfg.max_iterations);

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            px_reg <= pixel_x;
            py_reg <= pixel_y;
        end
        if (cmd.map_mul || cmd.iter_mul)
        begin
            for (int k = 0; k < 3; k++)
            begin
                prod_reg[k] <= prod_next[k];
            end
            sgn_reg <= sgn_next;
        end
        if (cmd.map_add)
        begin
            cx_reg    <= cx_new;
            cy_reg    <= cy_new;
            zx_reg    <= '0;
            zy_reg    <= '0;
            count_reg <= '0;
            addr_reg  <= prod_reg[2][ADDR_W-1:0] + ADDR_W'(px_reg);
        end
        if (cmd.iter_upd && !status.iter_done)
        begin
            zx_reg    <= sat_add(sat_add(xx, -yy), cx_reg);
            zy_reg    <= sat_add(xy2, cy_reg);
            count_reg <= count_reg + 1'b1;
        end
        if (cmd.load_out)
        begin
            esc_out_reg   <= (count_reg < cfg.max_iterations);
            count_out_reg <= count_reg;
            level_out_reg <= (count_reg < cfg.max_iterations) ? LEVEL_ESC : LEVEL_INSIDE;
            addr_out_reg  <= addr_reg;
        end
    end

    assign escaped         = esc_out_reg;
    assign iteration_count = count_out_reg;
    assign pixel_level     = level_out_reg;
    assign pixel_address   = addr_out_reg;

endmodule

`default_nettype wire

// ===== tb/mandelbrot_escape_time_pixel_core_test.sv =====
`timescale 1ns / 100ps

module mandelbrot_escape_time_pixel_core_test;
    import mbet_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = '1;
    localparam int HOLD_CYCLES = 300;
    localparam int PRINT_CAP   = 30;
    localparam int BATCH_ITEMS = 76;
    localparam int BATCHES     = 9;
    localparam int WILD_BATCH  = 3;
    localparam int CALM_BATCH  = 5;
    localparam int CLOG_BATCH  = 7;

    typedef struct packed {
        logic                   escaped;
        logic [COUNT_WIDTH-1:0] iteration_count;
        logic [LEVEL_W-1:0]     pixel_level;
        logic [ADDR_W-1:0]      pixel_address;
    } pixel_result_t;

    class escape_scoreboard;
        word_t                  center_re;
        word_t                  center_im;
        logic [STEP_W-1:0]      pixel_step;
        logic [SIZE_W-1:0]      image_width;
        logic [SIZE_W-1:0]      image_height;
        logic [COUNT_WIDTH-1:0] max_iterations;
        pixel_result_t          awaited[$];
        int                     failures;
        int                     checked;
        int                     escaped_count;
        int                     longest_orbit;

        function new();
            center_re      = '0;
            center_im      = '0;
            pixel_step     = STEP_RESET;
            image_width    = WIDTH_RESET;
            image_height   = HEIGHT_RESET;
            max_iterations = MAXIT_RESET;
            failures       = 0;
            checked        = 0;
            escaped_count  = 0;
            longest_orbit  = 0;
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] index,
                                     logic [CFG_DATA_W-1:0] data);
            case (index)
                REG_CENTER_RE:    center_re      = word_t'(data);
                REG_CENTER_IM:    center_im      = word_t'(data);
                REG_PIXEL_STEP:   pixel_step     = data[STEP_W-1:0];
                REG_IMAGE_WIDTH:  image_width    = data[SIZE_W-1:0];
                REG_IMAGE_HEIGHT: image_height   = data[SIZE_W-1:0];
                REG_MAX_ITER:     max_iterations = data[COUNT_WIDTH-1:0];
                default:          ;
            endcase
        endfunction

        function word_t clamp_word(longint v);
            if (v > longint'(QMAX))
                return QMAX;
            if (v < longint'(QMIN))
                return QMIN;
            return word_t'(v);
        endfunction

        function word_t add_clamped(word_t a, word_t b);
            return clamp_word(longint'(a) + longint'(b));
        endfunction

        // Magnitude is truncated before the sign is restored.
        function word_t mul_clamped(word_t a, word_t b, int shift);
            longint product;
            longint mag;
            product = longint'(a) * longint'(b);
            mag = (product < 0) ? -product : product;
            mag = mag >> shift;
            return clamp_word((product < 0) ? -mag : mag);
        endfunction

        function word_t plane_point(logic [COORD_WIDTH-1:0] pix, logic [SIZE_W-1:0] size,
                                    word_t offset);
            longint span;
            span = (2 * longint'(pix) - longint'(size)) * longint'(pixel_step);
            return add_clamped(clamp_word(span >>> 1), offset);
        endfunction

        function void note_pixel(logic [COORD_WIDTH-1:0] px, logic [COORD_WIDTH-1:0] py);
            word_t         cx;
            word_t         cy;
            word_t         zx;
            word_t         zy;
            word_t         xx;
            word_t         yy;
            word_t         xy2;
            int unsigned   count;
            longint        address;
            pixel_result_t want;
            cx = plane_point(px, image_width, center_re);
            cy = plane_point(py, image_height, center_im);
            zx = '0;
            zy = '0;
            count = 0;
            forever
            begin
                xx = mul_clamped(zx, zx, FRAC_BITS);
                yy = mul_clamped(zy, zy, FRAC_BITS);
                if (add_clamped(xx, yy) >= FOUR || count >= max_iterations)
                    break;
                xy2 = mul_clamped(zx, zy, FRAC_BITS - 1);
                zx = add_clamped(clamp_word(longint'(xx) - longint'(yy)), cx);
                zy = add_clamped(xy2, cy);
                count++;
            end
            address = longint'(py) * longint'(image_width) + longint'(px);
            want.escaped         = (count < max_iterations);
            want.iteration_count = count[COUNT_WIDTH-1:0];
            want.pixel_level     = want.escaped ? LEVEL_ESC : LEVEL_INSIDE;
            want.pixel_address   = address[ADDR_W-1:0];
            if (int'(count) > longest_orbit)
                longest_orbit = count;
            awaited.push_back(want);
        endfunction

        function void compare_field(string field, longint want, longint got);
            if (want != got)
            begin
                failures++;
                if (failures <= PRINT_CAP)
                    $display("%0t: %s mismatch, expected %0d, actual %0d",
                             $time, field, want, got);
            end
        endfunction

        function void check_result(pixel_result_t got);
            pixel_result_t want;
            if (awaited.size() == 0)
            begin
                failures++;
                if (failures <= PRINT_CAP)
                    $display("%0t: unexpected result, expected none, actual address %0d",
                             $time, got.pixel_address);
                return;
            end
            want = awaited.pop_front();
            checked++;
            if (want.escaped)
                escaped_count++;
            compare_field("escaped", longint'(want.escaped), longint'(got.escaped));
            compare_field("iteration_count", longint'(want.iteration_count),
                          longint'(got.iteration_count));
            compare_field("pixel_level", longint'(want.pixel_level),
                          longint'(got.pixel_level));
            compare_field("pixel_address", longint'(want.pixel_address),
                          longint'(got.pixel_address));
        endfunction

        function int pending();
            return awaited.size();
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    mbet_pixel_if  pix_bus();
    mbet_result_if res_bus();

    escape_scoreboard sb = new();
    bit gaps_on;
    bit hold_request;
    int views;

    mandelbrot_escape_time_pixel_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pixel     (pix_bus),
        .result    (res_bus),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("mandelbrot_escape_time_pixel_core test failed");
        $finish;
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        sb.write_register(index, data);
    endtask

    task automatic close_config();
        @(negedge clk);
        cfg_we <= 1'b0;
        views++;
    endtask

    task automatic set_view(word_t xo, word_t yo, logic [31:0] step, logic [31:0] width,
                            logic [31:0] height, logic [31:0] iters);
        write_reg(REG_CENTER_RE, xo);
        write_reg(REG_CENTER_IM, yo);
        write_reg(REG_PIXEL_STEP, step);
        write_reg(REG_IMAGE_WIDTH, width);
        write_reg(REG_IMAGE_HEIGHT, height);
        write_reg(REG_MAX_ITER, iters);
        close_config();
    endtask

    task automatic send_pixel(logic [COORD_WIDTH-1:0] x, logic [COORD_WIDTH-1:0] y);
        @(negedge clk);
        while (gaps_on && $urandom_range(99) < 33)
        begin
            pix_bus.valid <= 1'b0;
            @(negedge clk);
        end
        pix_bus.valid   <= 1'b1;
        pix_bus.pixel_x <= x;
        pix_bus.pixel_y <= y;
        do
            @(posedge clk);
        while (!pix_bus.ready);
        sb.note_pixel(x, y);
    endtask

    task automatic drain();
        @(negedge clk);
        pix_bus.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic random_pixels(int count);
        int                     x_span;
        int                     y_span;
        logic [COORD_WIDTH-1:0] x;
        logic [COORD_WIDTH-1:0] y;
        x_span = (sb.image_width > 4096) ? 4096 : sb.image_width;
        y_span = (sb.image_height > 4096) ? 4096 : sb.image_height;
        repeat (count)
        begin
            if (x_span != 0 && $urandom_range(99) < 80)
                x = COORD_WIDTH'($urandom_range(x_span - 1));
            else
                x = COORD_WIDTH'($urandom());
            if (y_span != 0 && $urandom_range(99) < 80)
                y = COORD_WIDTH'($urandom_range(y_span - 1));
            else
                y = COORD_WIDTH'($urandom());
            send_pixel(x, y);
        end
    endtask

    task automatic random_view(bit wild, int iter_cap);
        int     w;
        int     h;
        longint step;
        longint xo;
        longint yo;
        if (wild)
        begin
            set_view($urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                     $urandom_range(iter_cap));
        end
        else
        begin
            w = $urandom_range(8, 700);
            h = $urandom_range(8, 700);
            step = (longint'(1) << 30) / w * $urandom_range(50, 200) / 100;
            xo = longint'($urandom_range(1 << 29)) - (longint'(3) << 27);
            yo = longint'($urandom_range(1 << 29)) - (longint'(1) << 28);
            set_view(word_t'(xo), word_t'(yo), 32'(step), w, h, $urandom_range(1, iter_cap));
        end
    endtask

    initial
    begin
        int hold_left;
        hold_left = 0;
        res_bus.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                res_bus.ready <= 1'b0;
            end
            else if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left = HOLD_CYCLES;
                res_bus.ready <= 1'b0;
            end
            else
            begin
                res_bus.ready <= !(gaps_on && $urandom_range(99) < 33);
            end
        end
    end

    initial
    begin
        pixel_result_t got;
        forever
        begin
            @(posedge clk);
            if (rst_n && res_bus.valid && res_bus.ready)
            begin
                got = '{res_bus.escaped, res_bus.iteration_count, res_bus.pixel_level,
                        res_bus.pixel_address};
                sb.check_result(got);
            end
        end
    end

    initial
    begin
        gaps_on         = 1'b1;
        hold_request    = 1'b0;
        views           = 0;
        pix_bus.valid   = 1'b0;
        pix_bus.pixel_x = '0;
        pix_bus.pixel_y = '0;
        cfg_we          = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        rst_n           = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset view: corners, centre of the set, alternating bit patterns.
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd4095);
        send_pixel(12'd320, 12'd240);
        send_pixel(12'd0, 12'd4095);
        send_pixel(12'd4095, 12'd0);
        send_pixel(12'hAAA, 12'h555);
        send_pixel(12'h555, 12'hAAA);
        send_pixel(12'd639, 12'd479);
        drain();

        // A zero limit does no iteration, and a write to an unknown index changes nothing.
        write_reg(REG_MAX_ITER, 0);
        write_reg(REG_UNUSED, 32'h0000_0005);
        close_config();
        send_pixel(12'd320, 12'd240);
        send_pixel(12'd0, 12'd0);
        drain();

        set_view(QMAX, QMIN, 32'hFFFF_FFFF, 0, 32'h1FFF, 2);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd4095);
        send_pixel(12'd2048, 12'd0);
        drain();

        set_view(QMIN, QMIN, 0, 32'h1FFF, 0, 3);
        send_pixel(12'd4095, 12'd4095);
        send_pixel(12'd0, 12'd0);
        drain();

        set_view('0, '0, 32'(STEP_RESET), 32'(WIDTH_RESET), 32'(HEIGHT_RESET), 32'hFFFF);
        send_pixel(12'd320, 12'd240);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd100, 12'd50);
        drain();

        for (int b = 0; b < BATCHES; b++)
        begin
            if (b == WILD_BATCH)
                random_view(1'b1, 64);
            else if (b == CLOG_BATCH)
                random_view(1'b0, 8);
            else
                random_view(1'b0, 300);
            gaps_on = (b != CALM_BATCH);
            hold_request = (b == CLOG_BATCH);
            random_pixels(BATCH_ITEMS);
            drain();
        end

        repeat (64) @(posedge clk);
        $display("Checked %0d pixel results under %0d register settings, %0d of them escaped.",
                 sb.checked, views, sb.escaped_count);
        $display("Deepest orbit ran %0d iterations; offsets, step, sizes and limit hit extremes.",
                 sb.longest_orbit);
        if (sb.failures == 0)
            $display("mandelbrot_escape_time_pixel_core test passed");
        else
            $display("mandelbrot_escape_time_pixel_core test failed");
        $finish;
    end

endmodule

// ===== mandelbrot_escape_time_pixel_core.f =====
hw/rtl/mbet_pkg.sv
hw/rtl/mbet_pixel_if.sv
hw/rtl/mbet_result_if.sv
hw/rtl/mbet_cfg.sv
hw/rtl/mbet_ctrl.sv
hw/rtl/mbet_dp.sv
hw/rtl/mbet_core.sv
tb/mandelbrot_escape_time_pixel_core_test.sv
